// ===== rtl/tq_pkg.sv =====
// Shared widths, codes and types of the tile-to-quad block.
package tq_pkg;

    // Field widths
    localparam int COL_W        = 8;
    localparam int ROW_W        = 8;
    localparam int TILE_W       = 16;
    localparam int SIZE_W       = 9;
    localparam int MAPDIM_W     = 9;
    localparam int COUNT_W      = 2;
    localparam int SHEETCOL_W   = 11;
    localparam int CORNER_W     = 2;
    localparam int SX_W         = 17;
    localparam int SY_W         = 17;
    localparam int TU_W         = 19;
    localparam int TV_W         = 25;

    // Configuration port
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;

    // Tileset register slots
    localparam int SET_SLOTS    = 2;

    // Parameter defaults
    localparam int MAX_MAP_SIDE_DEF = 256;
    localparam int NUM_TILESETS_DEF = 2;

    // Divider pipeline: quotient bits resolved per stage
    localparam int DIV_STAGES   = 8;
    localparam int DIV_STEPS    = TILE_W / DIV_STAGES;

    // Reset values
    localparam logic [SIZE_W-1:0]     RST_TILE_SIZE  = 9'd16;
    localparam logic [MAPDIM_W-1:0]   RST_MAP_DIM    = 9'd256;
    localparam logic [COUNT_W-1:0]    RST_SETS       = 2'd0;
    localparam logic [TILE_W-1:0]     RST_BASE_ID    = 16'd1;
    localparam logic [SHEETCOL_W-1:0] RST_SHEET_COLS = 11'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TILE_SIZE   = 3'd0,
        CFG_MAP_WIDTH   = 3'd1,
        CFG_MAP_HEIGHT  = 3'd2,
        CFG_SETS_IN_USE = 3'd3,
        CFG_BASE_ZERO   = 3'd4,
        CFG_COLS_ZERO   = 3'd5,
        CFG_BASE_ONE    = 3'd6,
        CFG_COLS_ONE    = 3'd7
    } t_cfg_idx;

    localparam logic [CORNER_W-1:0] CORNER_TL = 2'd0;
    localparam logic [CORNER_W-1:0] CORNER_TR = 2'd1;
    localparam logic [CORNER_W-1:0] CORNER_BR = 2'd2;
    localparam logic [CORNER_W-1:0] CORNER_BL = 2'd3;

    // Side data carried alongside the divider
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             sel;
    } t_tag;

    // Pipeline control into the divider
    typedef struct packed {
        logic en;
        logic valid;
    } t_div_ctl;

    // Partial division state
    typedef struct packed {
        logic [TILE_W-1:0]     q;
        logic [SHEETCOL_W-1:0] r;
    } t_div_st;

endpackage

// ===== rtl/tq_ifs.sv =====
// Channel interfaces: cell requests, vertex results, configuration writes.
interface tq_cell_if;
    logic                        valid;
    logic                        ready;
    logic [tq_pkg::COL_W-1:0]    cell_column;
    logic [tq_pkg::ROW_W-1:0]    cell_row;
    logic [tq_pkg::TILE_W-1:0]   tile_number;

    modport source (output valid, cell_column, cell_row, tile_number, input ready);
    modport sink   (input valid, cell_column, cell_row, tile_number, output ready);
endinterface

interface tq_vtx_if;
    logic                         valid;
    logic                         ready;
    logic                         sheet_index;
    logic [tq_pkg::CORNER_W-1:0]  corner;
    logic [tq_pkg::SX_W-1:0]      screen_x;
    logic [tq_pkg::SY_W-1:0]      screen_y;
    logic [tq_pkg::TU_W-1:0]      texture_u;
    logic [tq_pkg::TV_W-1:0]      texture_v;
    logic                         last_corner;

    modport source (output valid, sheet_index, corner, screen_x, screen_y, texture_u,
                    texture_v, last_corner, input ready);
    modport sink   (input valid, sheet_index, corner, screen_x, screen_y, texture_u,
                    texture_v, last_corner, output ready);
endinterface

interface tq_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [tq_pkg::CFG_IDX_W-1:0]  index;
    logic [tq_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/tq_div.sv =====
// Pipelined restoring divider: tile index split into sheet row and column.
module tq_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  tq_pkg::t_div_ctl                  i_ctl,
    input  logic [tq_pkg::TILE_W-1:0]         i_dividend,
    input  logic [tq_pkg::SHEETCOL_W-1:0]     i_divisor,
    input  tq_pkg::t_tag                      i_tag,
    output logic                              o_valid,
    output logic [tq_pkg::TILE_W-1:0]         o_quot,
    output logic [tq_pkg::SHEETCOL_W-1:0]     o_rem,
    output logic [tq_pkg::SHEETCOL_W-1:0]     o_divisor,
    output tq_pkg::t_tag                      o_tag
);

    localparam int S  = tq_pkg::DIV_STAGES;
    localparam int K  = tq_pkg::DIV_STEPS;
    localparam int DW = tq_pkg::TILE_W;
    localparam int VW = tq_pkg::SHEETCOL_W;

    // K quotient bits: dividend bits shift out of q's top, quotient bits in at bottom
    function automatic tq_pkg::t_div_st div_steps(input logic [DW-1:0] q_in,
                                                  input logic [VW-1:0] r_in,
                                                  input logic [VW-1:0] d);
        logic [DW-1:0] q;
        logic [VW-1:0] r;
        logic [VW:0]   t;
        tq_pkg::t_div_st res;
        q = q_in;
        r = r_in;
        for (int k = 0; k < K; k++) begin
            t = {r, q[DW-1]};
            q = {q[DW-2:0], 1'b0};
            if (t >= {1'b0, d}) begin
                t    = t - {1'b0, d};
                q[0] = 1'b1;
            end
            r = t[VW-1:0];
        end
        res.q = q;
        res.r = r;
        return res;
    endfunction

    logic [S-1:0]    r_v;
    logic [DW-1:0]   r_q   [S];
    logic [VW-1:0]   r_r   [S];
    logic [VW-1:0]   r_d   [S];
    tq_pkg::t_tag    r_tag [S];
    tq_pkg::t_div_st n_st  [S];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_ctl.en) begin
            r_v <= {r_v[S-2:0], i_ctl.valid};
        end
    end

    for (genvar gs = 0; gs < S; gs++) begin : g_stage
        if (gs == 0) begin : g_first
            assign n_st[gs] = div_steps(i_dividend, '0, i_divisor);
            always_ff @(posedge i_clk) begin
                if (i_ctl.en) begin
                    r_q[gs]   <= n_st[gs].q;
                    r_r[gs]   <= n_st[gs].r;
                    r_d[gs]   <= i_divisor;
                    r_tag[gs] <= i_tag;
                end
            end
        end else begin : g_next
            assign n_st[gs] = div_steps(r_q[gs-1], r_r[gs-1], r_d[gs-1]);
            always_ff @(posedge i_clk) begin
                if (i_ctl.en) begin
                    r_q[gs]   <= n_st[gs].q;
                    r_r[gs]   <= n_st[gs].r;
                    r_d[gs]   <= r_d[gs-1];
                    r_tag[gs] <= r_tag[gs-1];
                end
            end
        end
    end

    assign o_valid   = r_v[S-1];
    assign o_quot    = r_q[S-1];
    assign o_rem     = r_r[S-1];
    assign o_divisor = r_d[S-1];
    assign o_tag     = r_tag[S-1];

endmodule

// ===== rtl/tile_to_textured_quad_unit.sv =====
// Top level: map cell requests in, four textured quad vertices out per drawn tile.
//
// Channels: i_cell takes one map cell request (column, row, global tile number);
// o_vtx delivers vertices (tileset, corner, screen x/y, texture u/v, last flag),
// four per drawn tile in the order top-left, top-right, bottom-right, bottom-left.
// i_cfg writes the eight setup registers; it is always ready and must only be
// used while no request is in flight.
// Empty cells, cells outside the map and tiles below the base of every tileset in use give
// no vertices and are dropped in the decode stage.
// Pipeline: decode stage, eight divider stages (two quotient bits each), one
// multiply stage, then the vertex register, which presents the first vertex of
// a tile on o_vtx.
// Flow: a request enters every cycle while i_cell.ready is high. The vertex register
// issues one vertex per cycle while o_vtx.ready is high; empty cells cost one
// pipeline slot. Sustained rate is set by the single vertex port.
// Stall: the vertex register holds a tile for its four vertices, longer while the
// receiver holds ready low; if the multiply stage also holds a tile the whole pipeline
// freezes, and i_cell.ready falls only then. Nothing is lost or repeated.
// Reset (i_rst_n low at a clock edge) empties the pipeline and loads the
// setup registers with their defaults.
module tile_to_textured_quad_unit #(
    parameter int MAX_MAP_SIDE = tq_pkg::MAX_MAP_SIDE_DEF,
    parameter int NUM_TILESETS = tq_pkg::NUM_TILESETS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tq_cell_if.sink     i_cell,
    tq_vtx_if.source    o_vtx,
    tq_cfg_if.sink      i_cfg
);

    localparam int SideW  = $clog2(MAX_MAP_SIDE + 1);
    localparam int LimW   = (SideW > tq_pkg::MAPDIM_W) ? SideW : tq_pkg::MAPDIM_W;
    localparam int SetLim = (NUM_TILESETS < tq_pkg::SET_SLOTS) ? NUM_TILESETS
                                                               : tq_pkg::SET_SLOTS;
    localparam logic [LimW-1:0]             SideLim = LimW'(MAX_MAP_SIDE);
    localparam logic [tq_pkg::COUNT_W-1:0]  SetLimC = tq_pkg::COUNT_W'(SetLim);

    // ---------------- setup registers ----------------
    logic [tq_pkg::SIZE_W-1:0]     r_tile_size;
    logic [tq_pkg::MAPDIM_W-1:0]   r_map_width;
    logic [tq_pkg::MAPDIM_W-1:0]   r_map_height;
    logic [tq_pkg::COUNT_W-1:0]    r_sets;
    logic [tq_pkg::TILE_W-1:0]     r_base [tq_pkg::SET_SLOTS];
    logic [tq_pkg::SHEETCOL_W-1:0] r_cols [tq_pkg::SET_SLOTS];

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tile_size  <= tq_pkg::RST_TILE_SIZE;
            r_map_width  <= tq_pkg::RST_MAP_DIM;
            r_map_height <= tq_pkg::RST_MAP_DIM;
            r_sets       <= tq_pkg::RST_SETS;
            r_base[0]    <= tq_pkg::RST_BASE_ID;
            r_base[1]    <= tq_pkg::RST_BASE_ID;
            r_cols[0]    <= tq_pkg::RST_SHEET_COLS;
            r_cols[1]    <= tq_pkg::RST_SHEET_COLS;
        end else if (i_cfg.valid) begin
            unique case (tq_pkg::t_cfg_idx'(i_cfg.index))
                tq_pkg::CFG_TILE_SIZE:   r_tile_size  <= i_cfg.data[tq_pkg::SIZE_W-1:0];
                tq_pkg::CFG_MAP_WIDTH:   r_map_width  <= i_cfg.data[tq_pkg::MAPDIM_W-1:0];
                tq_pkg::CFG_MAP_HEIGHT:  r_map_height <= i_cfg.data[tq_pkg::MAPDIM_W-1:0];
                tq_pkg::CFG_SETS_IN_USE: r_sets       <= i_cfg.data[tq_pkg::COUNT_W-1:0];
                tq_pkg::CFG_BASE_ZERO:   r_base[0]    <= i_cfg.data[tq_pkg::TILE_W-1:0];
                tq_pkg::CFG_COLS_ZERO:   r_cols[0]    <= i_cfg.data[tq_pkg::SHEETCOL_W-1:0];
                tq_pkg::CFG_BASE_ONE:    r_base[1]    <= i_cfg.data[tq_pkg::TILE_W-1:0];
                tq_pkg::CFG_COLS_ONE:    r_cols[1]    <= i_cfg.data[tq_pkg::SHEETCOL_W-1:0];
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    logic en;          // whole pipeline advances
    logic emit_load;   // vertex register takes the next tile
    logic out_fire;
    logic r_m_v;
    logic r_e_busy;
    logic [tq_pkg::CORNER_W-1:0] r_corner;

    assign out_fire     = r_e_busy && o_vtx.ready;
    assign emit_load    = !r_e_busy || (out_fire && (r_corner == tq_pkg::CORNER_BL));
    assign en           = !r_m_v || emit_load;
    assign i_cell.ready = en;

    // ---------------- decode stage ----------------
    logic [LimW-1:0]                w_lim, h_lim;
    logic [tq_pkg::COUNT_W-1:0]     set_cnt;
    logic                           hit0, hit1, drop;
    logic [tq_pkg::TILE_W-1:0]      base_sel;
    logic [tq_pkg::SHEETCOL_W-1:0]  cols_sel;

    always_comb begin
        w_lim    = (LimW'(r_map_width) > SideLim) ? SideLim : LimW'(r_map_width);
        h_lim    = (LimW'(r_map_height) > SideLim) ? SideLim : LimW'(r_map_height);
        set_cnt  = (r_sets > SetLimC) ? SetLimC : r_sets;
        // highest tileset in use whose base is at or below the tile wins
        hit1     = (set_cnt >= 2'd2) && (i_cell.tile_number >= r_base[1]);
        hit0     = (set_cnt >= 2'd1) && (i_cell.tile_number >= r_base[0]);
        base_sel = hit1 ? r_base[1] : r_base[0];
        cols_sel = hit1 ? r_cols[1] : r_cols[0];
        if (cols_sel == '0) begin
            cols_sel = tq_pkg::SHEETCOL_W'(1);
        end
        drop     = (i_cell.tile_number == '0)
                || (LimW'(i_cell.cell_column) >= w_lim)
                || (LimW'(i_cell.cell_row) >= h_lim)
                || !(hit0 || hit1);
    end

    logic                           r_a_v;
    logic [tq_pkg::TILE_W-1:0]      r_a_index;
    logic [tq_pkg::SHEETCOL_W-1:0]  r_a_cols;
    tq_pkg::t_tag                   r_a_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (en) begin
            r_a_v <= i_cell.valid && !drop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_index   <= i_cell.tile_number - base_sel;
            r_a_cols    <= cols_sel;
            r_a_tag.col <= i_cell.cell_column;
            r_a_tag.row <= i_cell.cell_row;
            r_a_tag.sel <= hit1;
        end
    end

    // ---------------- divider ----------------
    tq_pkg::t_div_ctl               div_ctl;
    logic                           div_v;
    logic [tq_pkg::TILE_W-1:0]      div_quot;
    logic [tq_pkg::SHEETCOL_W-1:0]  div_rem;
    logic [tq_pkg::SHEETCOL_W-1:0]  div_cols;
    tq_pkg::t_tag                   div_tag;

    assign div_ctl.en    = en;
    assign div_ctl.valid = r_a_v;

    tq_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (div_ctl),
        .i_dividend (r_a_index),
        .i_divisor  (r_a_cols),
        .i_tag      (r_a_tag),
        .o_valid    (div_v),
        .o_quot     (div_quot),
        .o_rem      (div_rem),
        .o_divisor  (div_cols),
        .o_tag      (div_tag)
    );

    // ---------------- multiply stage: top-left corner values ----------------
    logic [tq_pkg::SX_W-1:0]  r_m_x;
    logic [tq_pkg::SY_W-1:0]  r_m_y;
    logic [tq_pkg::TU_W-1:0]  r_m_u;
    logic [tq_pkg::TV_W-1:0]  r_m_v0;
    logic                     r_m_sel;
    logic [19:0]              prod_u;   // 11 x 9 bits
    logic [tq_pkg::TV_W-1:0]  prod_v;   // 16 x 9 bits

    assign prod_u = {9'd0, div_rem} * {11'd0, r_tile_size};
    assign prod_v = {9'd0, div_quot} * {16'd0, r_tile_size};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_v <= 1'b0;
        end else if (en) begin
            r_m_v <= div_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m_x   <= {9'd0, div_tag.col} * {8'd0, r_tile_size};
            r_m_y   <= {9'd0, div_tag.row} * {8'd0, r_tile_size};
            r_m_u   <= prod_u[tq_pkg::TU_W-1:0];
            r_m_v0  <= prod_v;
            r_m_sel <= div_tag.sel;
        end
    end

    // ---------------- vertex register ----------------
    // holds both edges of the quad; corner selects among them
    logic [tq_pkg::SX_W-1:0]  r_xa, r_xb;
    logic [tq_pkg::SY_W-1:0]  r_ya, r_yb;
    logic [tq_pkg::TU_W-1:0]  r_ua, r_ub;
    logic [tq_pkg::TV_W-1:0]  r_va, r_vb;
    logic                     r_e_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_busy <= 1'b0;
            r_corner <= tq_pkg::CORNER_TL;
        end else if (emit_load) begin
            r_e_busy <= r_m_v;
            r_corner <= tq_pkg::CORNER_TL;
        end else if (out_fire) begin
            r_corner <= r_corner + tq_pkg::CORNER_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_load) begin
            r_e_sel <= r_m_sel;
            r_xa    <= r_m_x;
            r_xb    <= r_m_x + {8'd0, r_tile_size};
            r_ya    <= r_m_y;
            r_yb    <= r_m_y + {8'd0, r_tile_size};
            r_ua    <= r_m_u;
            r_ub    <= r_m_u + {10'd0, r_tile_size};
            r_va    <= r_m_v0;
            r_vb    <= r_m_v0 + {16'd0, r_tile_size};
        end
    end

    logic right_edge, bottom_edge;
    assign right_edge  = (r_corner == tq_pkg::CORNER_TR) || (r_corner == tq_pkg::CORNER_BR);
    assign bottom_edge = (r_corner == tq_pkg::CORNER_BR) || (r_corner == tq_pkg::CORNER_BL);

    assign o_vtx.valid       = r_e_busy;
    assign o_vtx.sheet_index = r_e_sel;
    assign o_vtx.corner      = r_corner;
    assign o_vtx.screen_x    = right_edge  ? r_xb : r_xa;
    assign o_vtx.screen_y    = bottom_edge ? r_yb : r_ya;
    assign o_vtx.texture_u   = right_edge  ? r_ub : r_ua;
    assign o_vtx.texture_v   = bottom_edge ? r_vb : r_va;
    assign o_vtx.last_corner = (r_corner == tq_pkg::CORNER_BL);

    // ---------------- assertions ----------------
    a_rem_below_cols: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_v |-> (div_rem < div_cols))
        else $error("divider remainder not below column count");

    a_corner_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_vtx.valid && o_vtx.ready && !o_vtx.last_corner)
        |=> (o_vtx.valid && (o_vtx.corner == $past(o_vtx.corner) + 2'd1)))
        else $error("quad ended before its last corner");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cell.ready |-> (r_m_v && r_e_busy && !(o_vtx.ready && o_vtx.last_corner)))
        else $error("request stalled with room in the pipeline");

    a_new_quad_tl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_vtx.valid && o_vtx.ready && o_vtx.last_corner)
        |=> (!o_vtx.valid || (o_vtx.corner == tq_pkg::CORNER_TL)))
        else $error("quad did not start at top-left corner");

endmodule
